// ===== hdl/qnco_pkg.sv =====
// Shared types, constants and ROM-building functions for the quadrature NCO.
package qnco_pkg;

    localparam int PHASE_W           = 32;
    localparam int QUEUE_DEPTH       = 2;
    localparam int DEF_TABLE_DEPTH   = 1024;
    localparam int DEF_OUT_WIDTH     = 16;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 32;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP = 2'd0,
        REG_REVERSE    = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_queue_stat;

    // A * sin(pi/2 * r / quarter) with quarter = 2^qbits, Q30 Taylor series.
    function automatic longint unsigned quarter_sine(longint unsigned r, int qbits,
                                                     longint unsigned amp);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        x  = (r * Q30_HALF_PI + ((64'd1 << qbits) >> 1)) >> qbits;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 156;
        t  = Q30_ONE - ((x2 * t) >> 30) / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        return (s * amp + (Q30_ONE >> 1)) >> 30;
    endfunction

    // Full-cycle sine entry i of a 2^bits table, amplitude 2^(w-1)-1.
    function automatic longint rom_value(int i, int bits, int w);
        longint unsigned depth;
        longint unsigned quarter;
        longint unsigned amp;
        longint unsigned idx;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned v;
        depth   = 64'd1 << bits;
        quarter = depth >> 2;
        amp     = (64'd1 << (w - 1)) - 64'd1;
        idx     = longint'(i) & (depth - 64'd1);
        quad    = idx >> (bits - 2);
        r       = idx & (quarter - 64'd1);
        if (quad == 64'd1 || quad == 64'd3) begin
            r = quarter - r;
        end
        v = quarter_sine(r, bits - 2, amp);
        return (quad >= 64'd2) ? -longint'(v) : longint'(v);
    endfunction

endpackage

// ===== hdl/quadrature_nco_multiwave_core.sv =====
// Top level of the quadrature NCO: phase ramp, saw, triangle, sine and cosine.
//
// Input channel (i_in_valid / o_in_ready, i_tick): each request is one sample
// tick; tick = 1 moves the 32-bit phase by the step (down when reverse is set),
// tick = 0 keeps it. Every request yields exactly one result on the output
// channel (o_out_valid / i_out_ready) with five OUT_WIDTH-bit waveforms.
// Configuration: pulse i_cfg_we with i_cfg_idx = 0 (phase step) or 1 (reverse)
// while the block is idle; writes take effect at once, other indexes are dropped.
// Path: the accepting edge pushes the request's new phase into the queue, and the
// ROM reads are then loaded from the queue head into the output register once
// it is free or being drained. Throughput: one request per cycle while the
// receiver keeps up, set by the single accumulator add and the two-port ROM read.
// A two-entry phase queue sits between accumulator and ROM; when the receiver
// stalls, results hold in the output register, the queue fills and then
// o_in_ready drops until the receiver takes a result.
// Reset clears phase, step, reverse, queue and output valid.
module quadrature_nco_multiwave_core #(
    parameter int TABLE_DEPTH = qnco_pkg::DEF_TABLE_DEPTH,
    parameter int OUT_WIDTH   = qnco_pkg::DEF_OUT_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [qnco_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [qnco_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_tick,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [OUT_WIDTH-1:0]             o_phase_ramp,
    output logic signed [OUT_WIDTH-1:0]      o_saw,
    output logic [OUT_WIDTH-1:0]             o_triangle,
    output logic signed [OUT_WIDTH-1:0]      o_sine,
    output logic signed [OUT_WIDTH-1:0]      o_cosine
);
    import qnco_pkg::*;

    t_queue_stat        q_stat;
    logic               push;
    logic [PHASE_W-1:0] push_phase;
    logic               pop;
    logic [PHASE_W-1:0] head_phase;

    qnco_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_tick       (i_tick),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_push_phase (push_phase)
    );

    qnco_queue #(
        .WIDTH (PHASE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_phase),
        .i_pop       (pop),
        .o_head      (head_phase),
        .o_stat      (q_stat)
    );

    qnco_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .OUT_WIDTH   (OUT_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (q_stat),
        .i_phase      (head_phase),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_phase_ramp (o_phase_ramp),
        .o_saw        (o_saw),
        .o_triangle   (o_triangle),
        .o_sine       (o_sine),
        .o_cosine     (o_cosine)
    );

endmodule

// ===== hdl/qnco_front.sv =====
// Front end: configuration registers, phase accumulator and queue push.
module qnco_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [qnco_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [qnco_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_tick,
    input  qnco_pkg::t_queue_stat            i_q_stat,
    output logic                             o_push,
    output logic [qnco_pkg::PHASE_W-1:0]     o_push_phase
);
    import qnco_pkg::*;

    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic [PHASE_W-1:0] r_step;
    logic               r_reverse;
    logic               accept;

    assign o_in_ready = !i_q_stat.full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_phase = r_phase;
        if (i_tick) begin
            n_phase = r_reverse ? (r_phase - r_step) : (r_phase + r_step);
        end
    end

    assign o_push       = accept;
    assign o_push_phase = n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_step    <= '0;
            r_reverse <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    REG_PHASE_STEP: r_step    <= i_cfg_data[PHASE_W-1:0];
                    REG_REVERSE:    r_reverse <= i_cfg_data[0];
                    default:        ;
                endcase
            end
        end
    end

endmodule

// ===== hdl/qnco_queue.sv =====
// Short phase queue between the accumulator and the waveform back end.
module qnco_queue #(
    parameter int WIDTH = qnco_pkg::PHASE_W,
    parameter int DEPTH = qnco_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WIDTH-1:0]      i_push_data,
    input  logic                  i_pop,
    output logic [WIDTH-1:0]      o_head,
    output qnco_pkg::t_queue_stat o_stat
);
    import qnco_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_head           = r_mem[r_rd_ptr];
    assign o_stat.full      = (r_count == CNT_W'(DEPTH));
    assign o_stat.not_empty = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hdl/qnco_back.sv =====
// Back end: sine/cosine ROM read and waveform output register.
module qnco_back #(
    parameter int TABLE_DEPTH = qnco_pkg::DEF_TABLE_DEPTH,
    parameter int OUT_WIDTH   = qnco_pkg::DEF_OUT_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qnco_pkg::t_queue_stat         i_q_stat,
    input  logic [qnco_pkg::PHASE_W-1:0]  i_phase,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [OUT_WIDTH-1:0]          o_phase_ramp,
    output logic signed [OUT_WIDTH-1:0]   o_saw,
    output logic [OUT_WIDTH-1:0]          o_triangle,
    output logic signed [OUT_WIDTH-1:0]   o_sine,
    output logic signed [OUT_WIDTH-1:0]   o_cosine
);
    import qnco_pkg::*;

    localparam int IDX_W     = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int ROM_DEPTH = 1 << IDX_W;

    typedef logic [OUT_WIDTH-1:0] t_rom [ROM_DEPTH];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            rom[i] = OUT_WIDTH'(rom_value(i, IDX_W, OUT_WIDTH));
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();
    localparam logic [IDX_W-1:0] QUARTER = IDX_W'(ROM_DEPTH / 4);

    logic                 load;
    logic [IDX_W-1:0]     sin_idx;
    logic [IDX_W-1:0]     cos_idx;
    logic [OUT_WIDTH:0]   fold;
    logic [OUT_WIDTH-1:0] ramp;
    logic [OUT_WIDTH-1:0] tri_val;
    logic                 r_valid;
    logic [OUT_WIDTH-1:0] r_ramp;
    logic [OUT_WIDTH-1:0] r_saw;
    logic [OUT_WIDTH-1:0] r_tri;
    logic [OUT_WIDTH-1:0] r_sine;
    logic [OUT_WIDTH-1:0] r_cosine;

    // Take the next phase whenever the output register is free or being drained.
    assign load  = i_q_stat.not_empty && (!r_valid || i_out_ready);
    assign o_pop = load;

    assign sin_idx = i_phase[PHASE_W-1 -: IDX_W];
    assign cos_idx = sin_idx + QUARTER;
    assign ramp    = i_phase[PHASE_W-1 -: OUT_WIDTH];
    assign fold    = i_phase[PHASE_W-1 -: OUT_WIDTH+1];

    // Fold the second half of the cycle back down; saturate the exact peak.
    always_comb begin
        if (!fold[OUT_WIDTH]) begin
            tri_val = fold[OUT_WIDTH-1:0];
        end else if (fold[OUT_WIDTH-1:0] == '0) begin
            tri_val = '1;
        end else begin
            tri_val = '0 - fold[OUT_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ramp   <= ramp;
            r_saw    <= {~ramp[OUT_WIDTH-1], ramp[OUT_WIDTH-2:0]};
            r_tri    <= tri_val;
            r_sine   <= SINE_ROM[sin_idx];
            r_cosine <= SINE_ROM[cos_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_phase_ramp = r_ramp;
    assign o_saw        = r_saw;
    assign o_triangle   = r_tri;
    assign o_sine       = r_sine;
    assign o_cosine     = r_cosine;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the quadrature NCO core: directed and random sample ticks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qnco_pkg::*;

    localparam int TBL_DEPTH      = 1024;
    localparam int OUT_W          = 16;
    localparam int IDX_BITS       = $clog2(TBL_DEPTH + 1) - 1;
    localparam int TBL_EFF        = 1 << IDX_BITS;
    localparam int QUARTER        = TBL_EFF / 4;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_PRINTED    = 50;

    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Indexes past the two registers; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [OUT_W-1:0]        ramp;
        logic signed [OUT_W-1:0] saw;
        logic [OUT_W-1:0]        triangle;
        logic signed [OUT_W-1:0] sine;
        logic signed [OUT_W-1:0] cosine;
    } t_nco_sample;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_tick = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [OUT_W-1:0]        o_phase_ramp;
    logic signed [OUT_W-1:0] o_saw;
    logic [OUT_W-1:0]        o_triangle;
    logic signed [OUT_W-1:0] o_sine;
    logic signed [OUT_W-1:0] o_cosine;

    logic signed [OUT_W-1:0] sine_rom [TBL_EFF];
    logic [31:0]             phase_acc = '0;
    logic [31:0]             step_cfg = '0;
    logic                    reverse_cfg = 1'b0;
    t_nco_sample             expected_samples [$];
    int unsigned             mismatch_count = 0;
    int unsigned             result_count = 0;
    int unsigned             idle_cycles = 0;
    int unsigned             send_gap_pct = 16;
    int unsigned             recv_stall_pct = 78;

    quadrature_nco_multiwave_core #(
        .TABLE_DEPTH (TBL_DEPTH),
        .OUT_WIDTH   (OUT_W)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_tick       (i_tick),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_phase_ramp (o_phase_ramp),
        .o_saw        (o_saw),
        .o_triangle   (o_triangle),
        .o_sine       (o_sine),
        .o_cosine     (o_cosine)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Magnitude of A*sin(pi/2 * r / QUARTER), Q30 Taylor series through x^13.
    function automatic longint unsigned quarter_wave_mag(longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned amp;
        amp = (64'd1 << (OUT_W - 1)) - 64'd1;
        x   = (r * HALF_PI_Q30 + QUARTER / 2) / QUARTER;
        x2  = (x * x) >> 30;
        t   = ONE_Q30;
        for (int k = 6; k >= 1; k--) begin
            t = ONE_Q30 - ((x2 * t) >> 30) / longint'(2 * k * (2 * k + 1));
        end
        return ((((x * t) >> 30) * amp) + (ONE_Q30 >> 1)) >> 30;
    endfunction

    function automatic t_nco_sample predict_sample(logic [31:0] phase);
        t_nco_sample       s;
        logic [OUT_W:0]    fold;
        logic [IDX_BITS-1:0] sin_idx;
        logic [IDX_BITS-1:0] cos_idx;
        s.ramp = phase[31 -: OUT_W];
        s.saw  = {~phase[31], phase[30 -: OUT_W - 1]};
        fold   = phase[31 -: OUT_W + 1];
        if (!fold[OUT_W]) begin
            s.triangle = fold[OUT_W-1:0];
        end else if (fold[OUT_W-1:0] == '0) begin
            // half cycle: full scale does not fit, saturate
            s.triangle = '1;
        end else begin
            s.triangle = -fold[OUT_W-1:0];
        end
        sin_idx  = phase[31 -: IDX_BITS];
        cos_idx  = sin_idx + IDX_BITS'(QUARTER);
        s.sine   = sine_rom[sin_idx];
        s.cosine = sine_rom[cos_idx];
        return s;
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000 + $urandom_range(0, 4) - 2;
            3: return $urandom_range(1, 512);
            4: return $urandom >> $urandom_range(0, 31);
            5: return 32'($urandom_range(0, TBL_EFF - 1)) << (32 - IDX_BITS);
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("[%0t] result %0d: %s", $realtime, result_count, what);
        end
    endtask

    // Receiver: check each result against the oldest prediction, then reroll ready.
    always @(posedge i_clk) begin : check_results
        t_nco_sample want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = expected_samples.pop_front();
                if (o_phase_ramp !== want.ramp)
                    report_mismatch($sformatf("phase_ramp got %h want %h", o_phase_ramp,
                                              want.ramp));
                if (o_saw !== want.saw)
                    report_mismatch($sformatf("saw got %h want %h", o_saw, want.saw));
                if (o_triangle !== want.triangle)
                    report_mismatch($sformatf("triangle got %h want %h", o_triangle,
                                              want.triangle));
                if (o_sine !== want.sine)
                    report_mismatch($sformatf("sine got %h want %h", o_sine, want.sine));
                if (o_cosine !== want.cosine)
                    report_mismatch($sformatf("cosine got %h want %h", o_cosine,
                                              want.cosine));
            end
            result_count++;
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_tick(input logic tick_val);
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_gap_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_tick     <= tick_val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (tick_val) begin
            phase_acc = reverse_cfg ? phase_acc - step_cfg : phase_acc + step_cfg;
        end
        expected_samples.push_back(predict_sample(phase_acc));
    endtask

    // Hold off requests until every pending result is back and the pipe is empty.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Keep the write enable high across back-to-back writes; drop it after the last.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data, input bit last);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_PHASE_STEP: step_cfg = data;
            REG_REVERSE:    reverse_cfg = data[0];
            default: ;
        endcase
        if (last) i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] step, input logic [31:0] rev_data,
                              input bit with_spare);
        drain_results();
        write_register(REG_PHASE_STEP, step, 1'b0);
        write_register(REG_REVERSE, rev_data, !with_spare);
        if (with_spare) begin
            write_register($urandom_range(1) ? REG_SPARE_3 : REG_SPARE_2, $urandom, 1'b1);
        end
    endtask

    task automatic test_power_up_outputs();
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    task automatic test_triangle_peak();
        set_config(32'h8000_0000, 32'd0, 1'b0);
        repeat (3) send_tick(1'b1);
    endtask

    task automatic test_quarter_turns();
        set_config(32'h4000_0000, 32'd0, 1'b0);
        repeat (2) send_tick(1'b1);
        send_tick(1'b0);
        repeat (3) send_tick(1'b1);
    endtask

    task automatic test_full_scale_step();
        set_config(32'hFFFF_FFFF, 32'd0, 1'b0);
        repeat (2) send_tick(1'b1);
    endtask

    task automatic test_reverse_and_masking();
        // bit 0 clear in a wide value: stays forward
        set_config(32'h0000_0001, 32'hFFFF_FFFE, 1'b0);
        send_tick(1'b1);
        set_config(32'h0000_0001, 32'h0000_0003, 1'b0);
        repeat (3) send_tick(1'b1);
    endtask

    task automatic test_unused_indexes();
        drain_results();
        write_register(REG_SPARE_2, 32'hFFFF_FFFF, 1'b0);
        write_register(REG_SPARE_3, 32'hFFFF_FFFF, 1'b1);
        repeat (2) send_tick(1'b1);
    endtask

    task automatic test_drain_pause();
        set_config($urandom, 32'd0, 1'b0);
        repeat (20) send_tick(1'b1);
        drain_results();
        repeat (20) send_tick($urandom_range(99) < 85);
    endtask

    task automatic run_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                    input int count);
        int sent;
        int chunk;
        sent           = 0;
        send_gap_pct   = send_pct;
        recv_stall_pct = recv_pct;
        while (sent < count) begin
            chunk = $urandom_range(20, 90);
            set_config(pick_step(), $urandom, $urandom_range(3) == 0);
            repeat (chunk) send_tick($urandom_range(99) < 88);
            sent += chunk;
        end
    endtask

    initial begin
        longint unsigned quad;
        longint unsigned offset;
        longint unsigned mag;
        // full-cycle table by quarter-wave symmetry
        for (int i = 0; i < TBL_EFF; i++) begin
            quad   = i / QUARTER;
            offset = i % QUARTER;
            if (quad == 1 || quad == 3) offset = QUARTER - offset;
            mag = quarter_wave_mag(offset);
            sine_rom[i] = (quad >= 2) ? -mag[OUT_W-1:0] : mag[OUT_W-1:0];
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_power_up_outputs();
        test_triangle_peak();
        test_quarter_turns();
        test_full_scale_step();
        test_reverse_and_masking();
        test_unused_indexes();
        test_drain_pause();
        run_random_phase(16, 78, 520);
        run_random_phase(78, 16, 520);
        run_random_phase(0, 0, 520);
        drain_results();

        if (mismatch_count == 0 && expected_samples.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
